@@ rtl/quaternion_vector_rotate_top_assert.svh @@
// ----------------------------------------------------------------------------
// Quaternion vector rotate assertion macros
// Shared concurrent assertion macros for the rotator modules. They compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`ifndef SYNTHESIS
`define QVR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qvr assertion failed");
`else
`define QVR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`ifndef SYNTHESIS
`define QVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qvr assertion failed");
`else
`define QVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotate package
// Widths, register indexes and stage structs shared by the rotator files.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int COMPONENT_WIDTH = 24;
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int QUAT_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH   = 2;

    // Product of two quaternion components.
    localparam int PROD_WIDTH = 2 * QUAT_WIDTH;
    // Matrix entries (off-diagonal terms reach twice a product difference).
    localparam int MAT_WIDTH  = 2 * QUAT_WIDTH + 2;
    // Twice the squared length.
    localparam int DEN2_WIDTH = MAT_WIDTH;
    // Matrix entry times vector component.
    localparam int MUL_WIDTH  = MAT_WIDTH + COMPONENT_WIDTH;
    // Row sum of three products.
    localparam int NUM_WIDTH  = MUL_WIDTH + 2;
    // Dividend 2*|num| + den.
    localparam int DVD_WIDTH  = NUM_WIDTH + 2;

    localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(64'd1 << QUAT_FRAC_BITS);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_QUAT_REAL = 2'd0,
        REG_QUAT_I    = 2'd1,
        REG_QUAT_J    = 2'd2,
        REG_QUAT_K    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [QUAT_WIDTH-1:0] w;
        logic [QUAT_WIDTH-1:0] a;
        logic [QUAT_WIDTH-1:0] b;
        logic [QUAT_WIDTH-1:0] c;
    } t_quat;

    typedef struct packed {
        logic                       vld;
        logic [COMPONENT_WIDTH-1:0] x;
        logic [COMPONENT_WIDTH-1:0] y;
        logic [COMPONENT_WIDTH-1:0] z;
    } t_vec;

    typedef struct packed {
        logic                                 vld;
        logic                                 zero;
        logic [DEN2_WIDTH-1:0]                d2;
        logic [8:0][MAT_WIDTH-1:0]            m;
        logic [2:0][COMPONENT_WIDTH-1:0]      v;
    } t_mat;

    typedef struct packed {
        logic                  vld;
        logic                  zero;
        logic                  neg;
        logic [DEN2_WIDTH-1:0] d2;
        logic [DVD_WIDTH-1:0]  t;
    } t_lane;

    typedef struct packed {
        logic                       vld;
        logic [COMPONENT_WIDTH-1:0] val;
    } t_res;

endpackage

@@ rtl/qvr_vec_if.sv @@
// ----------------------------------------------------------------------------
// Input vector channel
// Valid/ready channel that carries one input vector per beat.
// ----------------------------------------------------------------------------
interface qvr_vec_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [qvr_pkg::COMPONENT_WIDTH-1:0] vec_x;
    logic signed [qvr_pkg::COMPONENT_WIDTH-1:0] vec_y;
    logic signed [qvr_pkg::COMPONENT_WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

@@ rtl/qvr_rot_if.sv @@
// ----------------------------------------------------------------------------
// Rotated vector channel
// Valid/ready channel that carries one rotated vector per beat.
// ----------------------------------------------------------------------------
interface qvr_rot_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [qvr_pkg::COMPONENT_WIDTH-1:0] rot_x;
    logic signed [qvr_pkg::COMPONENT_WIDTH-1:0] rot_y;
    logic signed [qvr_pkg::COMPONENT_WIDTH-1:0] rot_z;

    modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
    modport sink   (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

@@ rtl/qvr_matrix.sv @@
// ----------------------------------------------------------------------------
// Rotation matrix stages
// Two stages: quaternion component products, then the unnormalized rotation
// matrix and twice the squared length.
// ----------------------------------------------------------------------------
module qvr_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  qvr_pkg::t_quat i_quat,
    input  qvr_pkg::t_vec i_vec,
    output qvr_pkg::t_mat o_mat
);
    localparam int PW = qvr_pkg::PROD_WIDTH;
    localparam int MW = qvr_pkg::MAT_WIDTH;
    localparam int CW = qvr_pkg::COMPONENT_WIDTH;

    logic signed [PW-1:0] n_ww, n_aa, n_bb, n_cc, n_ab, n_wc, n_ac, n_wb, n_bc, n_wa;
    logic signed [PW-1:0] r_ww, r_aa, r_bb, r_cc, r_ab, r_wc, r_ac, r_wb, r_bc, r_wa;
    logic [2:0][CW-1:0]   r_v1;
    logic                 r_vld1;

    logic signed [MW-1:0] e_ww, e_aa, e_bb, e_cc, e_ab, e_wc, e_ac, e_wb, e_bc, e_wa;
    logic signed [MW-1:0] n_norm;
    logic [8:0][MW-1:0]   n_m;
    qvr_pkg::t_mat        r_mat;

    // Stage 1: ten products of the quaternion components.
    always_comb begin
        n_ww = $signed(i_quat.w) * $signed(i_quat.w);
        n_aa = $signed(i_quat.a) * $signed(i_quat.a);
        n_bb = $signed(i_quat.b) * $signed(i_quat.b);
        n_cc = $signed(i_quat.c) * $signed(i_quat.c);
        n_ab = $signed(i_quat.a) * $signed(i_quat.b);
        n_wc = $signed(i_quat.w) * $signed(i_quat.c);
        n_ac = $signed(i_quat.a) * $signed(i_quat.c);
        n_wb = $signed(i_quat.w) * $signed(i_quat.b);
        n_bc = $signed(i_quat.b) * $signed(i_quat.c);
        n_wa = $signed(i_quat.w) * $signed(i_quat.a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vec.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= n_ww;
            r_aa <= n_aa;
            r_bb <= n_bb;
            r_cc <= n_cc;
            r_ab <= n_ab;
            r_wc <= n_wc;
            r_ac <= n_ac;
            r_wb <= n_wb;
            r_bc <= n_bc;
            r_wa <= n_wa;
            r_v1 <= {i_vec.z, i_vec.y, i_vec.x};
        end
    end

    // Stage 2: matrix entries and the squared length.
    always_comb begin
        e_ww = MW'(r_ww);
        e_aa = MW'(r_aa);
        e_bb = MW'(r_bb);
        e_cc = MW'(r_cc);
        e_ab = MW'(r_ab);
        e_wc = MW'(r_wc);
        e_ac = MW'(r_ac);
        e_wb = MW'(r_wb);
        e_bc = MW'(r_bc);
        e_wa = MW'(r_wa);
        n_norm = e_ww + e_aa + e_bb + e_cc;
        n_m[0] = e_ww + e_aa - e_bb - e_cc;
        n_m[1] = (e_ab - e_wc) <<< 1;
        n_m[2] = (e_ac + e_wb) <<< 1;
        n_m[3] = (e_ab + e_wc) <<< 1;
        n_m[4] = e_ww - e_aa + e_bb - e_cc;
        n_m[5] = (e_bc - e_wa) <<< 1;
        n_m[6] = (e_ac - e_wb) <<< 1;
        n_m[7] = (e_bc + e_wa) <<< 1;
        n_m[8] = e_ww - e_aa - e_bb + e_cc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat.vld <= 1'b0;
        end else if (i_en) begin
            r_mat.vld <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat.zero <= (n_norm == '0);
            r_mat.d2   <= {n_norm[MW-2:0], 1'b0};
            r_mat.m    <= n_m;
            r_mat.v    <= r_v1;
        end
    end

    assign o_mat = r_mat;

endmodule

@@ rtl/qvr_mac.sv @@
// ----------------------------------------------------------------------------
// Matrix-vector stages
// Three stages: nine matrix-by-component products, row sums, and the
// rounding dividend 2*|sum| + den for each row.
// ----------------------------------------------------------------------------
module qvr_mac (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  qvr_pkg::t_mat           i_mat,
    output qvr_pkg::t_lane [2:0]    o_lane
);
    localparam int MW = qvr_pkg::MAT_WIDTH;
    localparam int DW = qvr_pkg::DEN2_WIDTH;
    localparam int PW = qvr_pkg::MUL_WIDTH;
    localparam int NW = qvr_pkg::NUM_WIDTH;
    localparam int TW = qvr_pkg::DVD_WIDTH;

    logic signed [PW-1:0] n_p [0:2][0:2];
    logic signed [PW-1:0] r_p [0:2][0:2];
    logic                 r_vld3, r_zero3;
    logic [DW-1:0]        r_d2_3;

    logic signed [NW-1:0] n_sum [0:2];
    logic signed [NW-1:0] r_sum [0:2];
    logic                 r_vld4, r_zero4;
    logic [DW-1:0]        r_d2_4;

    logic [TW-1:0]        n_den;
    logic signed [TW-1:0] n_two [0:2];
    logic [TW-1:0]        n_t [0:2];
    qvr_pkg::t_lane [2:0] r_lane;

    // Stage 3: products.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_p[r][c] = $signed(i_mat.m[r * 3 + c]) * $signed(i_mat.v[c]);
            end
        end
    end

    // Stage 4: row sums.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = NW'(r_p[r][0]) + NW'(r_p[r][1]) + NW'(r_p[r][2]);
        end
    end

    // Stage 5: t = 2*|sum| + den, folded into one add or subtract.
    always_comb begin
        n_den = {{(TW - DW + 1){1'b0}}, r_d2_4[DW-1:1]};
        for (int r = 0; r < 3; r++) begin
            n_two[r] = TW'(r_sum[r]) <<< 1;
            n_t[r]   = r_sum[r][NW-1] ? (n_den - n_two[r]) : (n_den + n_two[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                r_lane[r].vld <= 1'b0;
            end
        end else if (i_en) begin
            r_vld3  <= i_mat.vld;
            r_vld4  <= r_vld3;
            r_p     <= n_p;
            r_zero3 <= i_mat.zero;
            r_d2_3  <= i_mat.d2;
            r_sum   <= n_sum;
            r_zero4 <= r_zero3;
            r_d2_4  <= r_d2_3;
            for (int r = 0; r < 3; r++) begin
                r_lane[r].vld  <= r_vld4;
                r_lane[r].zero <= r_zero4;
                r_lane[r].neg  <= r_sum[r][NW-1];
                r_lane[r].d2   <= r_d2_4;
                r_lane[r].t    <= n_t[r];
            end
        end
    end

    assign o_lane = r_lane;

endmodule

@@ rtl/qvr_div_lane.sv @@
// ----------------------------------------------------------------------------
// Rounding divider lane
// Pipelined restoring divider, one quotient bit per stage, followed by a
// saturate and sign stage. Computes round(num / den) for one row.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_top_assert.svh"

module qvr_div_lane (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  qvr_pkg::t_lane i_lane,
    output qvr_pkg::t_res  o_res
);
    localparam int CW = qvr_pkg::COMPONENT_WIDTH;
    localparam int DW = qvr_pkg::DEN2_WIDTH;
    localparam int TW = qvr_pkg::DVD_WIDTH;
    localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW - 1){1'b0}}};

    logic          r_vld  [0:CW];
    logic          r_zero [0:CW];
    logic          r_neg  [0:CW];
    logic          r_ovf  [0:CW];
    logic [DW-1:0] r_d2   [0:CW];
    logic [DW-1:0] r_rem  [0:CW];
    logic [CW-1:0] r_q    [0:CW];
    logic [CW-1:0] r_tl   [0:CW-1];

    logic          n_ovf;
    logic [DW:0]   n_trial [1:CW];
    logic [DW:0]   n_diff  [1:CW];
    logic          n_ge    [1:CW];
    logic [DW-1:0] n_rem   [1:CW];

    logic [CW-1:0] n_lim, n_mag, n_res;
    logic          r_res_vld;
    logic [CW-1:0] r_res;

    // A quotient that needs more than CW bits always saturates.
    assign n_ovf = i_lane.t[TW-1:CW] >= {{(TW - CW - DW){1'b0}}, i_lane.d2};

    always_comb begin
        for (int k = 1; k <= CW; k++) begin
            n_trial[k] = {r_rem[k-1], r_tl[k-1][CW-1]};
            n_diff[k]  = n_trial[k] - {1'b0, r_d2[k-1]};
            n_ge[k]    = n_trial[k] >= {1'b0, r_d2[k-1]};
            n_rem[k]   = n_ge[k] ? n_diff[k][DW-1:0] : n_trial[k][DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CW; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_res_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_lane.vld;
            for (int k = 1; k <= CW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_res_vld <= r_vld[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_lane.zero;
            r_neg[0]  <= i_lane.neg;
            r_ovf[0]  <= n_ovf;
            r_d2[0]   <= i_lane.d2;
            r_rem[0]  <= i_lane.t[CW+DW-1:CW];
            r_q[0]    <= '0;
            r_tl[0]   <= i_lane.t[CW-1:0];
            for (int k = 1; k <= CW; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_d2[k]   <= r_d2[k-1];
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= {r_q[k-1][CW-2:0], n_ge[k]};
            end
            for (int k = 1; k < CW; k++) begin
                r_tl[k] <= {r_tl[k-1][CW-2:0], 1'b0};
            end
        end
    end

    // Saturate to the field range, apply the sign, and force zero for a
    // zero-length quaternion.
    always_comb begin
        n_lim = r_neg[CW] ? LIM_NEG : LIM_POS;
        n_mag = (r_ovf[CW] || (r_q[CW] > n_lim)) ? n_lim : r_q[CW];
        if (r_zero[CW]) begin
            n_res = '0;
        end else if (r_neg[CW]) begin
            n_res = ~n_mag + 1'b1;
        end else begin
            n_res = n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res.vld = r_res_vld;
    assign o_res.val = r_res;

    `QVR_ASSERT_IMPL(a_den_nonzero, i_clk, i_rst_n, r_vld[0] && !r_zero[0], r_d2[0] != '0)
    `QVR_ASSERT_IMPL(a_rem_init, i_clk, i_rst_n, r_vld[0] && !r_ovf[0], r_rem[0] < r_d2[0])
    `QVR_ASSERT_IMPL(a_rem_last, i_clk, i_rst_n, r_vld[CW] && !r_ovf[CW], r_rem[CW] < r_d2[CW])

endmodule

@@ rtl/quaternion_vector_rotate_top.sv @@
// Pipeline: an accepted vector passes through 5 matrix/MAC stages,
// 26 divider stages and the output register.
// Throughput: one vector per cycle; the whole pipeline stalls only when both
// the output register and the skid register hold unaccepted beats.
// Reset: synchronous active-low; clears all valid bits and loads identity.
// ----------------------------------------------------------------------------
// Quaternion vector rotate top level
// Rotates each input vector by the configured quaternion as q v q^-1, with
// the division by the squared length done in a bit-per-stage divider,
// rounding half away from zero and saturating to the component range.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_top_assert.svh"

module quaternion_vector_rotate_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]       i_cfg_data,
    qvr_vec_if.sink                              i_vec,
    qvr_rot_if.source                            o_rot
);
    localparam int CW = qvr_pkg::COMPONENT_WIDTH;

    qvr_pkg::t_quat       r_quat;
    qvr_pkg::t_vec        n_vec;
    qvr_pkg::t_mat        mat;
    qvr_pkg::t_lane [2:0] lane;
    qvr_pkg::t_res        res [0:2];

    logic                 en;
    logic                 last_vld;
    logic [3*CW-1:0]      n_data;
    logic                 r_out_vld, n_out_vld;
    logic                 r_skid_vld, n_skid_vld;
    logic [3*CW-1:0]      r_out, r_skid;
    logic                 load_out, load_skid, drain_skid;

    // Configuration registers. Writes must arrive only while the pipeline is
    // empty; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= qvr_pkg::QUAT_ONE;
            r_quat.a <= '0;
            r_quat.b <= '0;
            r_quat.c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qvr_pkg::REG_QUAT_REAL: r_quat.w <= i_cfg_data;
                qvr_pkg::REG_QUAT_I:    r_quat.a <= i_cfg_data;
                qvr_pkg::REG_QUAT_J:    r_quat.b <= i_cfg_data;
                qvr_pkg::REG_QUAT_K:    r_quat.c <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves as one; it halts only while the skid register is
    // occupied, which means two finished beats are already waiting.
    assign en          = !r_skid_vld;
    assign i_vec.ready = en;

    always_comb begin
        n_vec.vld = i_vec.valid && en;
        n_vec.x   = i_vec.vec_x;
        n_vec.y   = i_vec.vec_y;
        n_vec.z   = i_vec.vec_z;
    end

    qvr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_quat  (r_quat),
        .i_vec   (n_vec),
        .o_mat   (mat)
    );

    qvr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mat   (mat),
        .o_lane  (lane)
    );

    // One divider lane per output component.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        qvr_div_lane u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_lane  (lane[g]),
            .o_res   (res[g])
        );
    end

    assign last_vld = res[0].vld && res[1].vld && res[2].vld;
    assign n_data   = {res[2].val, res[1].val, res[0].val};

    // Output register plus skid register. A finished beat goes to the output
    // register when it is free or being taken, otherwise into the skid
    // register. The skid register refills the output register first.
    always_comb begin
        drain_skid = r_skid_vld && o_rot.ready;
        load_out   = !r_skid_vld && last_vld && (!r_out_vld || o_rot.ready);
        load_skid  = !r_skid_vld && last_vld && r_out_vld && !o_rot.ready;
        n_skid_vld = r_skid_vld;
        n_out_vld  = r_out_vld;
        if (drain_skid) begin
            n_skid_vld = 1'b0;
            n_out_vld  = 1'b1;
        end else if (load_out) begin
            n_out_vld = 1'b1;
        end else if (load_skid) begin
            n_skid_vld = 1'b1;
        end else if (o_rot.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_skid) begin
            r_out <= r_skid;
        end else if (load_out) begin
            r_out <= n_data;
        end
        if (load_skid) begin
            r_skid <= n_data;
        end
    end

    assign o_rot.valid = r_out_vld;
    assign o_rot.rot_x = r_out[CW-1:0];
    assign o_rot.rot_y = r_out[2*CW-1:CW];
    assign o_rot.rot_z = r_out[3*CW-1:2*CW];

    `QVR_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    `QVR_ASSERT_IMPL(a_lanes_agree, i_clk, i_rst_n, res[0].vld, res[1].vld && res[2].vld)
    `QVR_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, load_skid, r_skid_vld && r_out_vld)
    `QVR_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, drain_skid, !r_skid_vld && r_out_vld)

endmodule
